// File: rtl/pwrd_pkg.sv
`timescale 1ns / 1ps
package pwrd_pkg;

	localparam int ID_BITS = 25;

	localparam int DUR_W  = 21;
	localparam int MAG_W  = 20;
	localparam int TOL_W  = 7;
	localparam int PROD_W = 28;
	localparam int CFG_W  = 20;
	localparam int IDX_W  = 3;
	localparam int ID_W   = 32;
	localparam int CNT_W  = 6;
	localparam int STAT_W = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_SHORT_PULSE = 3'd0;
	localparam logic [IDX_W-1:0] REG_LONG_PULSE  = 3'd1;
	localparam logic [IDX_W-1:0] REG_SHORT_GAP   = 3'd2;
	localparam logic [IDX_W-1:0] REG_LONG_GAP    = 3'd3;
	localparam logic [IDX_W-1:0] REG_REPEAT_GAP  = 3'd4;
	localparam logic [IDX_W-1:0] REG_TOL         = 3'd5;
	localparam logic [IDX_W-1:0] REG_WIDE_TOL    = 3'd6;

	// Report status codes; a running verdict uses the same codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_POL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
	localparam logic [STAT_W-1:0] ST_FEW     = 2'd3;

	typedef struct packed {
		logic [MAG_W-1:0] short_pulse;
		logic [MAG_W-1:0] long_pulse;
		logic [MAG_W-1:0] short_gap;
		logic [MAG_W-1:0] long_gap;
		logic [MAG_W-1:0] repeat_gap;
		logic [TOL_W-1:0] tol;
		logic [TOL_W-1:0] wide_tol;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		short_pulse: 20'd300,
		long_pulse:  20'd900,
		short_gap:   20'd300,
		long_gap:    20'd900,
		repeat_gap:  20'd9000,
		tol:         7'd25,
		wide_tol:    7'd50
	};

	// Window bounds kept scaled by 100 so no division is needed
	typedef struct packed {
		logic [PROD_W-1:0] lo;
		logic [PROD_W-1:0] hi;
	} window_t;

	typedef struct packed {
		window_t repeat_gap;
		window_t short_pulse;
		window_t long_gap;
		window_t long_pulse;
		window_t short_gap;
	} bounds_t;

	function automatic window_t calc_window(logic [MAG_W-1:0] e, logic [TOL_W-1:0] t);
		logic [TOL_W-1:0] lo_f;
		logic [7:0]       hi_f;
		window_t          w;
		lo_f = (t >= 7'd100) ? 7'd0 : 7'd100 - t;
		hi_f = 8'd100 + 8'(t);
		w.lo = PROD_W'(e) * PROD_W'(lo_f);
		w.hi = PROD_W'(e) * PROD_W'(hi_f);
		return w;
	endfunction

	function automatic bounds_t calc_bounds(cfg_t c);
		bounds_t b;
		b.repeat_gap  = calc_window(c.repeat_gap, c.tol);
		b.short_pulse = calc_window(c.short_pulse, c.tol);
		b.long_gap    = calc_window(c.long_gap, c.wide_tol);
		b.long_pulse  = calc_window(c.long_pulse, c.tol);
		b.short_gap   = calc_window(c.short_gap, c.tol);
		return b;
	endfunction

endpackage

// File: rtl/pwrd_in_if.sv
`timescale 1ns / 1ps
interface pwrd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pwrd_pkg::DUR_W-1:0]    duration;
	logic                                 frame_end;

	modport source (output valid, output duration, output frame_end, input ready);
	modport sink   (input valid, input duration, input frame_end, output ready);
endinterface

// File: rtl/pwrd_out_if.sv
`timescale 1ns / 1ps
interface pwrd_out_if;
	logic                          valid;
	logic                          ready;
	logic [pwrd_pkg::STAT_W-1:0]   status;
	logic [pwrd_pkg::ID_W-1:0]     decoded_id;

	modport source (output valid, output status, output decoded_id, input ready);
	modport sink   (input valid, input status, input decoded_id, output ready);
endinterface

// File: rtl/pwrd_bounds.sv
`timescale 1ns / 1ps
module pwrd_bounds (
	input  logic              clk,
	input  logic              arst_n,
	input  pwrd_pkg::cfg_t    cfg,
	output pwrd_pkg::bounds_t bounds
);

	pwrd_pkg::bounds_t bounds_q;

	// Recompute every window each cycle; registered, so it trails the config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q <= pwrd_pkg::calc_bounds(pwrd_pkg::CFG_RESET);
		end else begin
			bounds_q <= pwrd_pkg::calc_bounds(cfg);
		end
	end

	assign bounds = bounds_q;

endmodule

// File: rtl/pulse_width_remote_decoder.sv
`timescale 1ns / 1ps
// Pulse-width on/off-keyed remote decoder.
// frame: one signed duration per transaction (positive = pulse, negative
//   = gap) plus frame_end on the last duration of a captured frame.
// report: one transaction per frame, issued for the frame_end duration,
//   carrying status (ok, polarity error, no bit match, too few bits) and the
//   decoded id, MSB first, zero unless status is ok.
// cfg_we/cfg_index/cfg_wdata: write-only register port; the user must write
//   it while the decoder is idle (unenforced); frame.ready drops on a write.
// Timing: a duration is taken into an input stage and decoded from there
//   against window bounds precomputed from the registers (one small
//   multiplier per bound, registered). A report loads when its frame_end
//   leaves the input stage. One duration per cycle, save stalls and writes.
// Reset: registers return to their defaults, the window bounds are reloaded
//   and the decoder seeks the first pulse of a new frame.
// Stall: the report register holds until report.ready; durations keep
//   flowing, and only a second frame_end waits in the input stage until the
//   pending report is taken.
module pulse_width_remote_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	pwrd_in_if.sink                           frame,
	pwrd_out_if.source                        report,
	input  logic                              cfg_we,
	input  logic [pwrd_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pwrd_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam logic [1:0] PH_SEEK  = 2'd0;
	localparam logic [1:0] PH_PULSE = 2'd1;
	localparam logic [1:0] PH_GAP   = 2'd2;
	localparam logic [1:0] PH_STOP  = 2'd3;

	// Configuration registers and derived window bounds
	pwrd_pkg::cfg_t    cfg_q;
	pwrd_pkg::bounds_t bounds;

	// Input stage
	logic                                valid_s1;
	logic signed [pwrd_pkg::DUR_W-1:0]   dur_s1;
	logic                                fend_s1;

	// Frame decode state
	logic [1:0]                          phase_q;
	logic signed [pwrd_pkg::DUR_W-1:0]   held_q;
	logic [pwrd_pkg::ID_W-1:0]           id_shift_q;
	logic [pwrd_pkg::CNT_W-1:0]          bits_q;
	logic [pwrd_pkg::STAT_W-1:0]         verdict_q;

	// Report register
	logic                                rpt_valid_q;
	logic [pwrd_pkg::STAT_W-1:0]         rpt_status_q;
	logic [pwrd_pkg::ID_W-1:0]           rpt_id_q;

	// Next-state logic
	logic                                out_free;
	logic                                s1_go;
	logic [1:0]                          phase_n;
	logic signed [pwrd_pkg::DUR_W-1:0]   held_n;
	logic [pwrd_pkg::ID_W-1:0]           id_shift_n;
	logic [pwrd_pkg::CNT_W-1:0]          bits_n;
	logic [pwrd_pkg::STAT_W-1:0]         verdict_n;
	logic [pwrd_pkg::STAT_W-1:0]         status_n;
	logic [pwrd_pkg::ID_W-1:0]           id_out_n;
	logic [pwrd_pkg::PROD_W-1:0]         pulse_m100;
	logic [pwrd_pkg::PROD_W-1:0]         gap_m100;
	logic                                pol_bad;
	logic                                rep_hit;
	logic                                zero_hit;
	logic                                one_hit;

	function automatic logic [pwrd_pkg::MAG_W-1:0] sat_mag(
		logic signed [pwrd_pkg::DUR_W-1:0] v);
		logic [pwrd_pkg::DUR_W-1:0] a;
		a = v[pwrd_pkg::DUR_W-1] ? pwrd_pkg::DUR_W'(-v) : pwrd_pkg::DUR_W'(v);
		return a[pwrd_pkg::DUR_W-1] ? '1 : a[pwrd_pkg::MAG_W-1:0];
	endfunction

	function automatic logic [pwrd_pkg::PROD_W-1:0] scale100(
		logic [pwrd_pkg::MAG_W-1:0] m);
		logic [pwrd_pkg::PROD_W-1:0] x;
		x = pwrd_pkg::PROD_W'(m);
		return (x << 6) + (x << 5) + (x << 2);
	endfunction

	// floor(P/100) <= m  <=>  P <= 100m + 99 ;  m <= floor(P/100)  <=>  100m <= P
	function automatic logic in_window(logic [pwrd_pkg::PROD_W-1:0] m100,
		pwrd_pkg::window_t w);
		return (w.lo <= m100 + pwrd_pkg::PROD_W'(99)) && (m100 <= w.hi);
	endfunction

	pwrd_bounds u_bounds (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.bounds (bounds)
	);

	// Register writes; truncate data to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pwrd_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pwrd_pkg::REG_SHORT_PULSE: cfg_q.short_pulse <= cfg_wdata;
				pwrd_pkg::REG_LONG_PULSE:  cfg_q.long_pulse  <= cfg_wdata;
				pwrd_pkg::REG_SHORT_GAP:   cfg_q.short_gap   <= cfg_wdata;
				pwrd_pkg::REG_LONG_GAP:    cfg_q.long_gap    <= cfg_wdata;
				pwrd_pkg::REG_REPEAT_GAP:  cfg_q.repeat_gap  <= cfg_wdata;
				pwrd_pkg::REG_TOL:         cfg_q.tol         <= cfg_wdata[pwrd_pkg::TOL_W-1:0];
				pwrd_pkg::REG_WIDE_TOL:    cfg_q.wide_tol    <= cfg_wdata[pwrd_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the input stage drains unless it holds a frame end
	// and the report register is still occupied.
	assign out_free    = !rpt_valid_q || report.ready;
	assign s1_go       = valid_s1 && (!fend_s1 || out_free);
	assign frame.ready = !cfg_we && (!valid_s1 || s1_go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.valid && frame.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			dur_s1  <= frame.duration;
			fend_s1 <= frame.frame_end;
		end
	end

	// Pair checks against the precomputed windows
	assign pulse_m100 = scale100(sat_mag(held_q));
	assign gap_m100   = scale100(sat_mag(dur_s1));
	assign pol_bad    = (held_q <= 0) || (dur_s1 >= 0);
	assign rep_hit    = in_window(gap_m100, bounds.repeat_gap);
	assign zero_hit   = in_window(pulse_m100, bounds.short_pulse) &&
	                    in_window(gap_m100, bounds.long_gap);
	assign one_hit    = in_window(pulse_m100, bounds.long_pulse) &&
	                    in_window(gap_m100, bounds.short_gap);

	always_comb begin
		phase_n    = phase_q;
		held_n     = held_q;
		id_shift_n = id_shift_q;
		bits_n     = bits_q;
		verdict_n  = verdict_q;
		case (phase_q)
			PH_SEEK: begin
				if (dur_s1 > 0) begin
					held_n  = dur_s1;
					phase_n = PH_GAP;
				end
			end
			PH_PULSE: begin
				held_n  = dur_s1;
				phase_n = PH_GAP;
			end
			PH_GAP: begin
				if (pol_bad) begin
					verdict_n = pwrd_pkg::ST_POL;
				end else if (rep_hit) begin
					// Packet separator: restart the id
					id_shift_n = '0;
					bits_n     = '0;
				end else if (zero_hit) begin
					id_shift_n = {id_shift_q[pwrd_pkg::ID_W-2:0], 1'b0};
					bits_n     = bits_q + 1'b1;
				end else if (one_hit) begin
					id_shift_n = {id_shift_q[pwrd_pkg::ID_W-2:0], 1'b1};
					bits_n     = bits_q + 1'b1;
				end else begin
					verdict_n = pwrd_pkg::ST_NOMATCH;
				end
				if (verdict_n != pwrd_pkg::ST_OK ||
				    bits_n >= pwrd_pkg::CNT_W'(pwrd_pkg::ID_BITS)) begin
					phase_n = PH_STOP;
				end else begin
					phase_n = PH_PULSE;
				end
			end
			default: ;
		endcase

		// Status as seen after this duration
		if (verdict_n != pwrd_pkg::ST_OK) begin
			status_n = verdict_n;
			id_out_n = '0;
		end else if (bits_n == pwrd_pkg::CNT_W'(pwrd_pkg::ID_BITS)) begin
			status_n = pwrd_pkg::ST_OK;
			id_out_n = id_shift_n;
		end else begin
			status_n = pwrd_pkg::ST_FEW;
			id_out_n = '0;
		end
	end

	// Advance the frame state; clear it after a frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEEK;
			held_q     <= '0;
			id_shift_q <= '0;
			bits_q     <= '0;
			verdict_q  <= pwrd_pkg::ST_OK;
		end else if (s1_go) begin
			if (fend_s1) begin
				phase_q    <= PH_SEEK;
				held_q     <= '0;
				id_shift_q <= '0;
				bits_q     <= '0;
				verdict_q  <= pwrd_pkg::ST_OK;
			end else begin
				phase_q    <= phase_n;
				held_q     <= held_n;
				id_shift_q <= id_shift_n;
				bits_q     <= bits_n;
				verdict_q  <= verdict_n;
			end
		end
	end

	// Report register: load on a frame end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else if (s1_go && fend_s1) begin
			rpt_valid_q <= 1'b1;
		end else if (report.ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && fend_s1) begin
			rpt_status_q <= status_n;
			rpt_id_q     <= id_out_n;
		end
	end

	assign report.valid      = rpt_valid_q;
	assign report.status     = rpt_status_q;
	assign report.decoded_id = rpt_id_q;

endmodule
